### rtl/core/amm_swap_quote_top_assert.svh
`ifndef AMM_SWAP_QUOTE_TOP_ASSERT_SVH
`define AMM_SWAP_QUOTE_TOP_ASSERT_SVH

// Both macros expect clk and rst_n to be visible where they are used.
`define ASQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amm_swap_quote assertion failed");

`define ASQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amm_swap_quote assertion failed");

`endif

### rtl/core/asq_pkg.sv
`default_nettype none

package asq_pkg;

    localparam logic [2:0] OpOut   = 3'd0;
    localparam logic [2:0] OpIn    = 3'd1;
    localparam logic [2:0] OpEff   = 3'd2;
    localparam logic [2:0] OpCheck = 3'd3;
    localparam logic [2:0] OpSpot  = 3'd4;

    localparam logic [13:0] BpsFull  = 14'd10000;
    localparam logic [13:0] FeeReset = 14'd30;
    localparam logic [63:0] PriceOne = 64'h0DE0B6B3A7640000;

    localparam int QuoW = 128;

    typedef struct packed {
        logic [2:0]  op;
        logic        ok;
        logic        passed;
        logic [63:0] ain;
    } sb1_t;

    typedef struct packed {
        logic        is_eff;
        logic        inner;
        logic [63:0] amount;
        logic        passed;
        logic        ovf;
    } sb2_t;

endpackage

`default_nettype wire

### rtl/core/asq_front.sv
`default_nettype none

module asq_front import asq_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          item_valid,
    input  logic [2:0]    operation,
    input  logic [63:0]   amount_in,
    input  logic [63:0]   amount_out,
    input  logic [63:0]   reserve_in,
    input  logic [63:0]   reserve_out,
    input  logic [13:0]   fee_bps,
    output logic          front_valid,
    output logic [127:0]  num,
    output logic [127:0]  den,
    output sb1_t          side
);

    // Stage 1: decode and operand selection.
    logic [13:0]  adj_next;
    logic [63:0]  diff_next;
    logic [63:0]  x_next;
    logic [63:0]  y_next;
    logic [13:0]  c_next;
    logic [63:0]  g_next;
    logic         ok_next;
    logic         drain_ok;

    logic         s1_v_reg;
    logic [2:0]   s1_op_reg;
    logic         s1_ok_reg;
    logic [63:0]  s1_ain_reg;
    logic [63:0]  s1_rin_reg;
    logic [63:0]  s1_diff_reg;
    logic [13:0]  s1_adj_reg;
    logic [63:0]  s1_x_reg;
    logic [63:0]  s1_y_reg;
    logic [13:0]  s1_c_reg;
    logic [63:0]  s1_g_reg;

    always_comb
    begin
        adj_next  = (fee_bps > BpsFull) ? 14'd0 : BpsFull - fee_bps;
        diff_next = reserve_out - amount_out;
        drain_ok  = amount_out < reserve_out;
        x_next    = '0;
        y_next    = '0;
        c_next    = '0;
        ok_next   = 1'b0;
        g_next    = (operation == OpIn) ? diff_next : amount_in;
        case (operation)
            OpOut, OpEff:
            begin
                x_next  = reserve_out;
                y_next  = amount_in;
                c_next  = adj_next;
                ok_next = (amount_in != 0) && (reserve_in != 0) && (reserve_out != 0);
            end
            OpIn:
            begin
                x_next  = reserve_in;
                y_next  = amount_out;
                c_next  = BpsFull;
                ok_next = (amount_out != 0) && (reserve_in != 0) && (reserve_out != 0)
                          && drain_ok && (adj_next != 0);
            end
            OpCheck:
            begin
                x_next  = reserve_in;
                y_next  = reserve_out;
                c_next  = BpsFull;
                ok_next = (amount_in != 0) && (amount_out != 0) && drain_ok;
            end
            OpSpot:
            begin
                x_next  = reserve_out;
                y_next  = PriceOne;
                c_next  = 14'd1;
                ok_next = reserve_in != 0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Stage 2: partial products.
    logic         s2_v_reg;
    logic [2:0]   s2_op_reg;
    logic         s2_ok_reg;
    logic [63:0]  s2_ain_reg;
    logic [63:0]  s2_rin_reg;
    logic [63:0]  s2_diff_reg;
    logic [13:0]  s2_c_reg;
    logic [63:0]  s2_p00_reg;
    logic [63:0]  s2_p01_reg;
    logic [63:0]  s2_p10_reg;
    logic [63:0]  s2_p11_reg;
    logic [45:0]  s2_ga_lo_reg;
    logic [45:0]  s2_ga_hi_reg;
    logic [45:0]  s2_gb_lo_reg;
    logic [45:0]  s2_gb_hi_reg;

    // Stage 3: product sums and divisor.
    logic [127:0] p_next;
    logic [79:0]  ga_next;
    logic [79:0]  gb_next;
    logic [79:0]  den_next;

    logic         s3_v_reg;
    logic [2:0]   s3_op_reg;
    logic         s3_ok_reg;
    logic [63:0]  s3_ain_reg;
    logic [63:0]  s3_diff_reg;
    logic [13:0]  s3_c_reg;
    logic [127:0] s3_p_reg;
    logic [79:0]  s3_den_reg;

    always_comb
    begin
        p_next  = {64'd0, s2_p00_reg} + ({64'd0, s2_p01_reg} << 32)
                  + ({64'd0, s2_p10_reg} << 32) + {s2_p11_reg, 64'd0};
        ga_next = {34'd0, s2_ga_lo_reg} + ({34'd0, s2_ga_hi_reg} << 32);
        gb_next = {34'd0, s2_gb_lo_reg} + ({34'd0, s2_gb_hi_reg} << 32);
        case (s2_op_reg)
            OpIn:    den_next = gb_next;
            OpSpot:  den_next = {16'd0, s2_rin_reg};
            default: den_next = ga_next + gb_next;
        endcase
    end

    // Stage 4: scaling and check partial products.
    logic         s4_v_reg;
    logic [2:0]   s4_op_reg;
    logic         s4_ok_reg;
    logic [63:0]  s4_ain_reg;
    logic [79:0]  s4_den_reg;
    logic [45:0]  s4_pc_reg [4];
    logic [63:0]  s4_n0d0_reg;
    logic [63:0]  s4_n0d1_reg;
    logic [63:0]  s4_n1d0_reg;
    logic [63:0]  s4_n1d1_reg;
    logic [47:0]  s4_n2d0_reg;
    logic [47:0]  s4_n2d1_reg;

    // Stage 5: sums modulo 2^128.
    logic [127:0] num_next;
    logic [127:0] kaft_next;

    logic         s5_v_reg;
    logic [2:0]   s5_op_reg;
    logic         s5_ok_reg;
    logic [63:0]  s5_ain_reg;
    logic [79:0]  s5_den_reg;
    logic [127:0] s5_num_reg;
    logic [127:0] s5_kaft_reg;

    always_comb
    begin
        num_next  = {82'd0, s4_pc_reg[0]} + ({82'd0, s4_pc_reg[1]} << 32)
                    + ({82'd0, s4_pc_reg[2]} << 64) + ({82'd0, s4_pc_reg[3]} << 96);
        kaft_next = {64'd0, s4_n0d0_reg}
                    + ({64'd0, s4_n0d1_reg} << 32) + ({64'd0, s4_n1d0_reg} << 32)
                    + ({64'd0, s4_n1d1_reg} << 64) + ({80'd0, s4_n2d0_reg} << 64)
                    + ({80'd0, s4_n2d1_reg} << 96);
    end

    // Stage 6: invariant compare.
    logic         s6_v_reg;
    logic [127:0] s6_num_reg;
    logic [127:0] s6_den_reg;
    sb1_t         s6_sb_reg;
    sb1_t         sb_next;

    always_comb
    begin
        sb_next.op     = s5_op_reg;
        sb_next.ok     = s5_ok_reg;
        sb_next.ain    = s5_ain_reg;
        sb_next.passed = (s5_op_reg == OpCheck) && s5_ok_reg && (s5_kaft_reg >= s5_num_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= item_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= operation;
            s1_ok_reg    <= ok_next;
            s1_ain_reg   <= amount_in;
            s1_rin_reg   <= reserve_in;
            s1_diff_reg  <= diff_next;
            s1_adj_reg   <= adj_next;
            s1_x_reg     <= x_next;
            s1_y_reg     <= y_next;
            s1_c_reg     <= c_next;
            s1_g_reg     <= g_next;

            s2_op_reg    <= s1_op_reg;
            s2_ok_reg    <= s1_ok_reg;
            s2_ain_reg   <= s1_ain_reg;
            s2_rin_reg   <= s1_rin_reg;
            s2_diff_reg  <= s1_diff_reg;
            s2_c_reg     <= s1_c_reg;
            s2_p00_reg   <= s1_x_reg[31:0] * s1_y_reg[31:0];
            s2_p01_reg   <= s1_x_reg[31:0] * s1_y_reg[63:32];
            s2_p10_reg   <= s1_x_reg[63:32] * s1_y_reg[31:0];
            s2_p11_reg   <= s1_x_reg[63:32] * s1_y_reg[63:32];
            s2_ga_lo_reg <= s1_rin_reg[31:0] * BpsFull;
            s2_ga_hi_reg <= s1_rin_reg[63:32] * BpsFull;
            s2_gb_lo_reg <= s1_g_reg[31:0] * s1_adj_reg;
            s2_gb_hi_reg <= s1_g_reg[63:32] * s1_adj_reg;

            s3_op_reg    <= s2_op_reg;
            s3_ok_reg    <= s2_ok_reg;
            s3_ain_reg   <= s2_ain_reg;
            s3_diff_reg  <= s2_diff_reg;
            s3_c_reg     <= s2_c_reg;
            s3_p_reg     <= p_next;
            s3_den_reg   <= den_next;

            s4_op_reg    <= s3_op_reg;
            s4_ok_reg    <= s3_ok_reg;
            s4_ain_reg   <= s3_ain_reg;
            s4_den_reg   <= s3_den_reg;
            s4_pc_reg[0] <= s3_p_reg[31:0] * s3_c_reg;
            s4_pc_reg[1] <= s3_p_reg[63:32] * s3_c_reg;
            s4_pc_reg[2] <= s3_p_reg[95:64] * s3_c_reg;
            s4_pc_reg[3] <= s3_p_reg[127:96] * s3_c_reg;
            s4_n0d0_reg  <= s3_den_reg[31:0] * s3_diff_reg[31:0];
            s4_n0d1_reg  <= s3_den_reg[31:0] * s3_diff_reg[63:32];
            s4_n1d0_reg  <= s3_den_reg[63:32] * s3_diff_reg[31:0];
            s4_n1d1_reg  <= s3_den_reg[63:32] * s3_diff_reg[63:32];
            s4_n2d0_reg  <= s3_den_reg[79:64] * s3_diff_reg[31:0];
            s4_n2d1_reg  <= s3_den_reg[79:64] * s3_diff_reg[63:32];

            s5_op_reg    <= s4_op_reg;
            s5_ok_reg    <= s4_ok_reg;
            s5_ain_reg   <= s4_ain_reg;
            s5_den_reg   <= s4_den_reg;
            s5_num_reg   <= num_next;
            s5_kaft_reg  <= kaft_next;

            s6_num_reg   <= s5_num_reg;
            s6_den_reg   <= {48'd0, s5_den_reg};
            s6_sb_reg    <= sb_next;
        end
    end

    assign front_valid = s6_v_reg;
    assign num         = s6_num_reg;
    assign den         = s6_den_reg;
    assign side        = s6_sb_reg;

endmodule

`default_nettype wire

### rtl/core/asq_div.sv
`default_nettype none

module asq_div #(
    parameter int DivW  = 128,
    parameter int SideW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [DivW-1:0]  num,
    input  logic [DivW-1:0]  den,
    input  logic [SideW-1:0] side_in,
    output logic             out_valid,
    output logic [DivW-1:0]  quo,
    output logic [SideW-1:0] side_out
);

    // One quotient bit per stage; the numerator shifts out of the top of
    // nq while quotient bits shift in at the bottom.
    logic [DivW-1:0]  v_reg;
    logic [DivW-1:0]  r_reg  [DivW];
    logic [DivW-1:0]  nq_reg [DivW];
    logic [DivW-1:0]  d_reg  [DivW];
    logic [SideW-1:0] s_reg  [DivW];

    for (genvar i = 0; i < DivW; i++)
    begin : g_stage
        logic [DivW-1:0]  r_in;
        logic [DivW-1:0]  nq_in;
        logic [DivW-1:0]  d_in;
        logic [SideW-1:0] s_in;
        logic             v_in;
        logic [DivW-1:0]  r_shift;
        logic [DivW-1:0]  r_next;
        logic [DivW-1:0]  nq_next;
        logic             take;

        if (i == 0)
        begin : g_first
            assign r_in  = '0;
            assign nq_in = num;
            assign d_in  = den;
            assign s_in  = side_in;
            assign v_in  = in_valid;
        end
        else
        begin : g_rest
            assign r_in  = r_reg[i-1];
            assign nq_in = nq_reg[i-1];
            assign d_in  = d_reg[i-1];
            assign s_in  = s_reg[i-1];
            assign v_in  = v_reg[i-1];
        end

        always_comb
        begin
            r_shift = {r_in[DivW-2:0], nq_in[DivW-1]};
            take    = r_in[DivW-1] || (r_shift >= d_in);
            r_next  = take ? r_shift - d_in : r_shift;
            nq_next = {nq_in[DivW-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[i]  <= r_next;
                nq_reg[i] <= nq_next;
                d_reg[i]  <= d_in;
                s_reg[i]  <= s_in;
            end
        end
    end

    assign out_valid = v_reg[DivW-1];
    assign quo       = nq_reg[DivW-1];
    assign side_out  = s_reg[DivW-1];

endmodule

`default_nettype wire

### rtl/core/asq_mid.sv
`default_nettype none

module asq_mid import asq_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [127:0]  quo,
    input  sb1_t          side,
    output logic          mid_valid,
    output logic [127:0]  num,
    output logic [127:0]  den,
    output sb2_t          result
);

    logic [63:0]  lo;
    logic         hi_nz;
    sb2_t         res_next;

    always_comb
    begin
        lo       = quo[63:0];
        hi_nz    = |quo[127:64];
        res_next = '0;
        case (side.op)
            OpOut, OpSpot:
            begin
                if (side.ok)
                begin
                    res_next.amount = lo;
                    res_next.ovf    = hi_nz;
                end
            end
            OpIn:
            begin
                if (side.ok)
                begin
                    res_next.amount = lo + 64'd1;
                    res_next.ovf    = hi_nz || (&lo);
                end
            end
            OpCheck:
            begin
                res_next.passed = side.passed;
            end
            OpEff:
            begin
                res_next.is_eff = side.ok && (lo != 64'd0);
                res_next.inner  = hi_nz;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    logic         m1_v_reg;
    sb2_t         m1_res_reg;
    logic [63:0]  m1_ain_reg;
    logic [63:0]  m1_pp_reg [4];

    logic [127:0] num_next;

    logic         m2_v_reg;
    sb2_t         m2_res_reg;
    logic [63:0]  m2_ain_reg;
    logic [127:0] m2_num_reg;

    always_comb
    begin
        num_next = {64'd0, m1_pp_reg[0]} + ({64'd0, m1_pp_reg[1]} << 32)
                   + ({64'd0, m1_pp_reg[2]} << 32) + {m1_pp_reg[3], 64'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_v_reg <= in_valid;
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_res_reg   <= res_next;
            m1_ain_reg   <= side.ain;
            m1_pp_reg[0] <= lo[31:0] * PriceOne[31:0];
            m1_pp_reg[1] <= lo[31:0] * PriceOne[63:32];
            m1_pp_reg[2] <= lo[63:32] * PriceOne[31:0];
            m1_pp_reg[3] <= lo[63:32] * PriceOne[63:32];

            m2_res_reg   <= m1_res_reg;
            m2_ain_reg   <= m1_ain_reg;
            m2_num_reg   <= num_next;
        end
    end

    assign mid_valid = m2_v_reg;
    assign num       = m2_num_reg;
    assign den       = {64'd0, m2_ain_reg};
    assign result    = m2_res_reg;

endmodule

`default_nettype wire

### rtl/core/amm_swap_quote_top.sv
// Throughput: one item per cycle unless the pipeline is held; the two
// 128-stage restoring dividers, one quotient bit per stage, set the depth
// but not the rate.
// The whole pipeline holds while a result waits and result_ready is low.
// Reset clears all valid bits and loads fee_bps with 30.
`default_nettype none

`include "amm_swap_quote_top_assert.svh"

module amm_swap_quote_top import asq_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          item_valid,
    output logic          item_ready,
    input  logic [2:0]    operation,
    input  logic [63:0]   amount_in,
    input  logic [63:0]   amount_out,
    input  logic [63:0]   reserve_in,
    input  logic [63:0]   reserve_out,
    output logic          result_valid,
    input  logic          result_ready,
    output logic [63:0]   amount,
    output logic          passed,
    output logic          quotient_overflow
);

    localparam int Side1W = $bits(sb1_t);
    localparam int Side2W = $bits(sb2_t);

    logic [13:0] fee_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {18'd0, fee_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fee_reg <= FeeReset;
        end
        else if (cfg_write)
        begin
            fee_reg <= pwdata[13:0];
        end
    end

    logic adv;
    logic result_valid_reg;

    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    logic         front_valid;
    logic [127:0] front_num;
    logic [127:0] front_den;
    sb1_t         front_sb;

    asq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item_valid  (item_valid),
        .operation   (operation),
        .amount_in   (amount_in),
        .amount_out  (amount_out),
        .reserve_in  (reserve_in),
        .reserve_out (reserve_out),
        .fee_bps     (fee_reg),
        .front_valid (front_valid),
        .num         (front_num),
        .den         (front_den),
        .side        (front_sb)
    );

    logic              div1_valid;
    logic [QuoW-1:0]   div1_quo;
    logic [Side1W-1:0] div1_side;

    asq_div #(
        .DivW  (QuoW),
        .SideW (Side1W)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .num       (front_num),
        .den       (front_den),
        .side_in   (front_sb),
        .out_valid (div1_valid),
        .quo       (div1_quo),
        .side_out  (div1_side)
    );

    logic         mid_valid;
    logic [127:0] mid_num;
    logic [127:0] mid_den;
    sb2_t         mid_res;

    asq_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div1_valid),
        .quo       (div1_quo),
        .side      (sb1_t'(div1_side)),
        .mid_valid (mid_valid),
        .num       (mid_num),
        .den       (mid_den),
        .result    (mid_res)
    );

    logic              div2_valid;
    logic [QuoW-1:0]   div2_quo;
    logic [Side2W-1:0] div2_side;
    sb2_t              fin;

    asq_div #(
        .DivW  (QuoW),
        .SideW (Side2W)
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mid_valid),
        .num       (mid_num),
        .den       (mid_den),
        .side_in   (mid_res),
        .out_valid (div2_valid),
        .quo       (div2_quo),
        .side_out  (div2_side)
    );

    logic [63:0] amount_next;
    logic        passed_next;
    logic        ovf_next;

    always_comb
    begin
        fin = sb2_t'(div2_side);
        if (fin.is_eff)
        begin
            amount_next = div2_quo[63:0];
            passed_next = 1'b0;
            ovf_next    = (|div2_quo[127:64]) || fin.inner;
        end
        else
        begin
            amount_next = fin.amount;
            passed_next = fin.passed;
            ovf_next    = fin.ovf;
        end
    end

    logic [63:0] amount_reg;
    logic        passed_reg;
    logic        ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= div2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            amount_reg <= amount_next;
            passed_reg <= passed_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign result_valid      = result_valid_reg;
    assign amount            = amount_reg;
    assign passed            = passed_reg;
    assign quotient_overflow = ovf_reg;

    `ASQ_ASSERT_NOW(a_passed_alone, result_valid && passed, amount == 64'd0 && !quotient_overflow)
    `ASQ_ASSERT_NEXT(a_stall_freezes, !adv, $stable(div1_valid) && $stable(mid_valid))
    `ASQ_ASSERT_NEXT(a_stall_keeps_result, !adv, result_valid_reg && $stable(amount_reg))

endmodule

`default_nettype wire
